### hw/rtl/fet_pkg.sv
// ----------------------------------------------------------------------------
// fet_pkg
// Shared types, register map and command codes of the fade envelope timer.
// ----------------------------------------------------------------------------
`default_nettype none

package fet_pkg;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_START_TIME    = 3'd0;
	localparam logic [2:0] REG_PLAY_DURATION = 3'd1;
	localparam logic [2:0] REG_INFINITE_MODE = 3'd2;
	localparam logic [2:0] REG_FADE_IN       = 3'd3;
	localparam logic [2:0] REG_FADE_OUT      = 3'd4;
	localparam logic [2:0] REG_PEAK_WEIGHT   = 3'd5;
	localparam logic [2:0] REG_TIME_DIVIDER  = 3'd6;
	localparam logic [2:0] REG_TIME_OFFSET   = 3'd7;

	localparam logic [16:0] PEAK_WEIGHT_RESET  = 17'd65536;
	localparam logic [10:0] TIME_DIVIDER_RESET = 11'd1;

	// request commands
	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_STOP   = 2'd1;
	localparam logic [1:0] CMD_PAUSE  = 2'd2;
	localparam logic [1:0] CMD_RESUME = 2'd3;

	// weight source
	localparam logic [1:0] W_ZERO = 2'd0;
	localparam logic [1:0] W_PEAK = 2'd1;
	localparam logic [1:0] W_DIV  = 2'd2;

	// serial divider step counts
	localparam logic [5:0] WDIV_STEPS = 6'd17;
	localparam logic [5:0] SDIV_STEPS = 6'd32;

	typedef struct packed {
		logic [30:0]        start_time;
		logic [30:0]        play_duration;
		logic               infinite_mode;
		logic [30:0]        fade_in;
		logic [30:0]        fade_out;
		logic [16:0]        peak_weight;
		logic [10:0]        time_divider;
		logic signed [31:0] time_offset;
	} cfg_t;

	typedef struct packed {
		logic load_item;
		logic apply_cmd;
		logic start_sdiv;
		logic add_base;
		logic set_now;
		logic eval;
		logic mul;
		logic start_wdiv;
		logic load_out;
	} dp_ctrl_t;

	typedef struct packed {
		logic tick_run;
		logic weight_div;
		logic div_busy;
	} dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/fet_in_if.sv
// ----------------------------------------------------------------------------
// fet_in_if
// Request channel: command and absolute time.
// ----------------------------------------------------------------------------
`default_nettype none

interface fet_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [30:0] now_time;

	modport source (output valid, output command, output now_time, input ready);
	modport sink (input valid, input command, input now_time, output ready);
endinterface

`default_nettype wire

### hw/rtl/fet_out_if.sv
// ----------------------------------------------------------------------------
// fet_out_if
// Result channel: blend weight, sample time and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface fet_out_if;
	logic               valid;
	logic               ready;
	logic [16:0]        weight;
	logic signed [31:0] sample_time;
	logic               pending;
	logic               active;
	logic               stopping;
	logic               expired;

	modport source (output valid, output weight, output sample_time, output pending,
		output active, output stopping, output expired, input ready);
	modport sink (input valid, input weight, input sample_time, input pending,
		input active, input stopping, input expired, output ready);
endinterface

`default_nettype wire

### hw/rtl/fet_regs.sv
// ----------------------------------------------------------------------------
// fet_regs
// APB configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module fet_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output fet_pkg::cfg_t      cfg,
	output logic               dur_wr,
	output logic [30:0]        dur_data
);

	fet_pkg::cfg_t cfg_q;
	logic          wr_en;
	logic [2:0]    idx;

	assign wr_en    = psel & penable & pwrite;
	assign idx      = paddr[4:2];
	assign cfg      = cfg_q;
	assign dur_wr   = wr_en && (idx == fet_pkg::REG_PLAY_DURATION);
	assign dur_data = pwdata[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_time    <= '0;
			cfg_q.play_duration <= '0;
			cfg_q.infinite_mode <= 1'b0;
			cfg_q.fade_in       <= '0;
			cfg_q.fade_out      <= '0;
			cfg_q.peak_weight   <= fet_pkg::PEAK_WEIGHT_RESET;
			cfg_q.time_divider  <= fet_pkg::TIME_DIVIDER_RESET;
			cfg_q.time_offset   <= '0;
		end else if (wr_en) begin
			unique case (idx)
				fet_pkg::REG_START_TIME:    cfg_q.start_time    <= pwdata[30:0];
				fet_pkg::REG_PLAY_DURATION: cfg_q.play_duration <= pwdata[30:0];
				fet_pkg::REG_INFINITE_MODE: cfg_q.infinite_mode <= pwdata[0];
				fet_pkg::REG_FADE_IN:       cfg_q.fade_in       <= pwdata[30:0];
				fet_pkg::REG_FADE_OUT:      cfg_q.fade_out      <= pwdata[30:0];
				fet_pkg::REG_PEAK_WEIGHT:   cfg_q.peak_weight   <= pwdata[16:0];
				fet_pkg::REG_TIME_DIVIDER:  cfg_q.time_divider  <= pwdata[10:0];
				fet_pkg::REG_TIME_OFFSET:   cfg_q.time_offset   <= $signed(pwdata);
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fet_pkg::REG_START_TIME:    prdata = {1'b0, cfg_q.start_time};
			fet_pkg::REG_PLAY_DURATION: prdata = {1'b0, cfg_q.play_duration};
			fet_pkg::REG_INFINITE_MODE: prdata = {31'b0, cfg_q.infinite_mode};
			fet_pkg::REG_FADE_IN:       prdata = {1'b0, cfg_q.fade_in};
			fet_pkg::REG_FADE_OUT:      prdata = {1'b0, cfg_q.fade_out};
			fet_pkg::REG_PEAK_WEIGHT:   prdata = {15'b0, cfg_q.peak_weight};
			fet_pkg::REG_TIME_DIVIDER:  prdata = {21'b0, cfg_q.time_divider};
			fet_pkg::REG_TIME_OFFSET:   prdata = cfg_q.time_offset;
			default:                    prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

### hw/rtl/fet_div.sv
// ----------------------------------------------------------------------------
// fet_div
// Radix-2 restoring divider, one quotient bit per cycle. The partial
// remainder is preloaded so a short quotient needs only a few steps.
// ----------------------------------------------------------------------------
`default_nettype none

module fet_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [30:0] rem_init,
	input  wire logic [31:0] dvd_init,
	input  wire logic [5:0]  cnt_init,
	input  wire logic [30:0] divisor,
	output logic             busy,
	output logic [31:0]      quo
);

	logic [30:0] rem_q;
	logic [31:0] dvd_q;
	logic [30:0] d_q;
	logic [5:0]  cnt_q;
	logic [32:0] trial;
	logic        ge;

	// remainder stays below the divisor, so the shifted value fits 32 bits
	assign trial = {1'b0, rem_q, dvd_q[31]} - {2'b0, d_q};
	assign ge    = ~trial[32];
	assign busy  = (cnt_q != 6'd0);
	assign quo   = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= cnt_init;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dvd_q <= dvd_init;
			d_q   <= divisor;
		end else if (busy) begin
			rem_q <= ge ? trial[30:0] : {rem_q[29:0], dvd_q[31]};
			dvd_q <= {dvd_q[30:0], ge};
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fet_dp.sv
// ----------------------------------------------------------------------------
// fet_dp
// Datapath: timer state, command effects, flags, weight and sample time.
// ----------------------------------------------------------------------------
`default_nettype none

module fet_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fet_pkg::cfg_t   cfg,
	input  wire logic            dur_wr,
	input  wire logic [30:0]     dur_data,
	input  wire fet_pkg::dp_ctrl_t ctrl,
	output fet_pkg::dp_stat_t    stat,
	input  wire logic [1:0]      item_command,
	input  wire logic [30:0]     item_now_time,
	output logic [16:0]          weight,
	output logic signed [31:0]   sample_time,
	output logic                 pending,
	output logic                 active,
	output logic                 stopping,
	output logic                 expired
);

	// timer state
	logic [31:0] live_q;
	logic [31:0] cur_rel_q;
	logic [31:0] last_rel_q;
	logic [31:0] base_q;
	logic [31:0] snow_q;
	logic        paused_q;

	// per-request working registers
	logic [1:0]  cmd_q;
	logic [31:0] rel_q;
	logic [31:0] frame_q;
	logic [1:0]  wsel_q;
	logic [30:0] mul_a_q;
	logic [30:0] wdiv_d_q;
	logic [47:0] prod_q;
	logic        pend_q, act_q, stop_q, expd_q;

	// result register
	logic [16:0] res_weight_q;
	logic [31:0] res_sample_q;
	logic        res_pend_q, res_act_q, res_stop_q, res_expd_q;

	logic               inf;
	logic signed [33:0] diff;
	logic signed [33:0] fo_s;
	logic               stop_now;
	logic [32:0]        stop_sum;
	logic [31:0]        stop_live;
	logic               pend_d, act_d, expd_d, diff_pos, fo_br, fi_br;
	logic [1:0]         wsel_d;
	logic [30:0]        div_one;
	logic [31:0]        sdiv_mag;
	logic               div_start, div_busy;
	logic [30:0]        div_rem_init, div_d;
	logic [31:0]        div_dvd_init, quo;
	logic [5:0]         div_cnt;
	logic [16:0]        weight_d;

	assign inf  = cfg.infinite_mode;
	// live duration minus time since start: end of job relative to now
	assign diff = $signed({{2{live_q[31]}}, live_q}) - $signed({{2{rel_q[31]}}, rel_q});
	assign fo_s = $signed({3'b0, cfg.fade_out});

	assign stop_now  = !inf && (diff <= fo_s);
	assign stop_sum  = {rel_q[31], rel_q} + {2'b0, cfg.fade_out};
	assign stop_live = (!stop_sum[32] && stop_sum[31]) ? 32'h7FFF_FFFF : stop_sum[31:0];

	assign pend_d   = rel_q[31];
	assign diff_pos = (diff > 34'sd0);
	assign act_d    = !pend_d && (inf || diff_pos);
	assign expd_d   = !inf && !diff_pos;
	assign fo_br    = act_d && !inf && (cfg.fade_out != 31'd0) && (diff < fo_s);
	assign fi_br    = act_d && (cfg.fade_in != 31'd0) && (rel_q[30:0] < cfg.fade_in);

	always_comb begin
		if (!act_d) begin
			wsel_d = fet_pkg::W_ZERO;
		end else if (fo_br || fi_br) begin
			wsel_d = fet_pkg::W_DIV;
		end else begin
			wsel_d = fet_pkg::W_PEAK;
		end
	end

	assign div_one  = (cfg.time_divider == 11'd0) ? 31'd1 : {20'b0, cfg.time_divider};
	assign sdiv_mag = frame_q[31] ? (32'd0 - frame_q) : frame_q;

	assign div_start    = ctrl.start_sdiv | ctrl.start_wdiv;
	assign div_rem_init = ctrl.start_wdiv ? prod_q[47:17] : 31'd0;
	assign div_dvd_init = ctrl.start_wdiv ? {prod_q[16:0], 15'b0} : sdiv_mag;
	assign div_cnt      = ctrl.start_wdiv ? fet_pkg::WDIV_STEPS : fet_pkg::SDIV_STEPS;
	assign div_d        = ctrl.start_wdiv ? wdiv_d_q : div_one;

	fet_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.rem_init (div_rem_init),
		.dvd_init (div_dvd_init),
		.cnt_init (div_cnt),
		.divisor  (div_d),
		.busy     (div_busy),
		.quo      (quo)
	);

	assign stat.tick_run   = (cmd_q == fet_pkg::CMD_TICK) && !paused_q;
	assign stat.weight_div = (wsel_d == fet_pkg::W_DIV);
	assign stat.div_busy   = div_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q     <= '0;
			cur_rel_q  <= '0;
			last_rel_q <= '0;
			base_q     <= '0;
			snow_q     <= '0;
			paused_q   <= 1'b0;
		end else begin
			if (dur_wr) begin
				live_q <= {1'b0, dur_data};
			end
			if (ctrl.apply_cmd) begin
				case (cmd_q)
					fet_pkg::CMD_TICK: begin
						cur_rel_q  <= rel_q;
						last_rel_q <= rel_q;
					end
					fet_pkg::CMD_STOP: begin
						if (!stop_now) begin
							live_q <= stop_live;
						end
					end
					fet_pkg::CMD_PAUSE: begin
						paused_q   <= 1'b1;
						last_rel_q <= cur_rel_q;
						base_q     <= snow_q;
					end
					default: begin
						paused_q <= 1'b0;
					end
				endcase
			end
			if (ctrl.add_base) begin
				base_q <= frame_q[31] ? (base_q - quo) : (base_q + quo);
			end
			if (ctrl.set_now) begin
				snow_q <= base_q + cfg.time_offset;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_item) begin
			cmd_q <= item_command;
			rel_q <= {1'b0, item_now_time} - {1'b0, cfg.start_time};
		end
		if (ctrl.apply_cmd) begin
			frame_q <= rel_q - last_rel_q;
		end
		if (ctrl.eval) begin
			pend_q   <= pend_d;
			act_q    <= act_d;
			stop_q   <= stop_now;
			expd_q   <= expd_d;
			wsel_q   <= wsel_d;
			mul_a_q  <= fo_br ? diff[30:0] : rel_q[30:0];
			wdiv_d_q <= fo_br ? cfg.fade_out : cfg.fade_in;
		end
		if (ctrl.mul) begin
			prod_q <= {31'b0, cfg.peak_weight} * {17'b0, mul_a_q};
		end
		if (ctrl.load_out) begin
			res_weight_q <= weight_d;
			res_sample_q <= snow_q;
			res_pend_q   <= pend_q;
			res_act_q    <= act_q;
			res_stop_q   <= stop_q;
			res_expd_q   <= expd_q;
		end
	end

	always_comb begin
		case (wsel_q)
			fet_pkg::W_PEAK: weight_d = cfg.peak_weight;
			fet_pkg::W_DIV:  weight_d = quo[16:0];
			default:         weight_d = 17'd0;
		endcase
	end

	assign weight      = res_weight_q;
	assign sample_time = $signed(res_sample_q);
	assign pending     = res_pend_q;
	assign active      = res_act_q;
	assign stopping    = res_stop_q;
	assign expired     = res_expd_q;

endmodule

`default_nettype wire

### hw/rtl/fet_ctrl.sv
// ----------------------------------------------------------------------------
// fet_ctrl
// Sequencer: walks one request through command, sample-time division (unpaused
// tick), flag evaluation, weight division (in a fade) and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fet_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output fet_pkg::dp_ctrl_t      ctrl,
	input  wire fet_pkg::dp_stat_t stat
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_CMD    = 4'd1;
	localparam logic [3:0] ST_SMAG   = 4'd2;
	localparam logic [3:0] ST_SDIV   = 4'd3;
	localparam logic [3:0] ST_SBASE  = 4'd4;
	localparam logic [3:0] ST_SNOW   = 4'd5;
	localparam logic [3:0] ST_EVAL   = 4'd6;
	localparam logic [3:0] ST_MUL    = 4'd7;
	localparam logic [3:0] ST_WSTART = 4'd8;
	localparam logic [3:0] ST_WDIV   = 4'd9;
	localparam logic [3:0] ST_OUT    = 4'd10;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctrl.load_item = 1'b1;
					state_d        = ST_CMD;
				end
			end
			ST_CMD: begin
				ctrl.apply_cmd = 1'b1;
				state_d        = stat.tick_run ? ST_SMAG : ST_EVAL;
			end
			ST_SMAG: begin
				ctrl.start_sdiv = 1'b1;
				state_d         = ST_SDIV;
			end
			ST_SDIV: begin
				if (!stat.div_busy) begin
					state_d = ST_SBASE;
				end
			end
			ST_SBASE: begin
				ctrl.add_base = 1'b1;
				state_d       = ST_SNOW;
			end
			ST_SNOW: begin
				ctrl.set_now = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				ctrl.eval = 1'b1;
				state_d   = stat.weight_div ? ST_MUL : ST_OUT;
			end
			ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = ST_WSTART;
			end
			ST_WSTART: begin
				ctrl.start_wdiv = 1'b1;
				state_d         = ST_WDIV;
			end
			ST_WDIV: begin
				if (!stat.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					ctrl.load_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/fade_envelope_timer_unit.sv
// ----------------------------------------------------------------------------
// fade_envelope_timer_unit
// Timing and linear fade envelope of one timed playback job.
//
//   port      dir   handshake         content
//   items     in    valid/ready       command, now_time
//   results   out   valid/ready       weight, sample_time, flags
//   apb       in    psel/penable      8 config registers at 4*index
//
// A stop, pause or resume request with a flat weight skips both divisions,
// while an unpaused tick inside a fade runs both: the shared serial
// divider spends 32 steps on the sample time and 17 on the fade weight.
// Reset clears the timer state and loads the register defaults.
// A finished result waits in the output register; the next request is taken
// while it waits, and the sequencer only stalls at its final step.
// ----------------------------------------------------------------------------
`default_nettype none

module fade_envelope_timer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	fet_in_if.sink           items,
	fet_out_if.source        results
);

	fet_pkg::cfg_t     cfg;
	fet_pkg::dp_ctrl_t ctrl;
	fet_pkg::dp_stat_t stat;
	logic              dur_wr;
	logic [30:0]       dur_data;

	assign pready = 1'b1;

	fet_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.cfg      (cfg),
		.dur_wr   (dur_wr),
		.dur_data (dur_data)
	);

	fet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	fet_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.dur_wr        (dur_wr),
		.dur_data      (dur_data),
		.ctrl          (ctrl),
		.stat          (stat),
		.item_command  (items.command),
		.item_now_time (items.now_time),
		.weight        (results.weight),
		.sample_time   (results.sample_time),
		.pending       (results.pending),
		.active        (results.active),
		.stopping      (results.stopping),
		.expired       (results.expired)
	);

endmodule

`default_nettype wire

### tb/fade_envelope_timer_unit_tb.sv
// ----------------------------------------------------------------------------
// fade_envelope_timer_unit_tb
// Self-checking bench for the fade envelope timer. A scripted run covers reset
// state, fade ramps, pause/resume, stop and register extremes, then random
// register settings each drive a sweep of requests across the job's lifetime.
// Every result is checked against a fixed value or an in-bench timer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fade_envelope_timer_unit_tb;

	localparam longint MAX_TICK       = 64'h7FFF_FFFF;
	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     PHASES         = 10;
	localparam int     PHASE_REQUESTS = 128;

	typedef struct packed {
		logic [16:0] weight;
		logic [31:0] sample_time;
		logic        pending;
		logic        active;
		logic        stopping;
		logic        expired;
	} envelope_t;

	typedef struct {
		bit          is_write;
		logic [2:0]  idx;
		logic [31:0] value;
		logic [1:0]  cmd;
		bit          typed;
		envelope_t   known;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	fet_in_if  items_ch ();
	fet_out_if results_ch ();

	fade_envelope_timer_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (items_ch),
		.results (results_ch)
	);

	// model of the timer
	fet_pkg::cfg_t shadow_cfg;
	logic [31:0]   tl_live_dur;
	logic [31:0]   tl_cur_rel;
	logic [31:0]   tl_last_rel;
	logic [31:0]   tl_base;
	logic [31:0]   tl_sample;
	bit            tl_paused;

	envelope_t   due_envelopes[$];
	plan_row_t   plan_rows[$];
	int          bad_count = 0;
	bit          no_idle = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void log_failure(string msg);
		bad_count++;
		if (bad_count <= 10)
			$display("%s", msg);
	endfunction

	function automatic bit fading_out(longint now_l);
		longint st, dur, fout;
		st   = longint'(shadow_cfg.start_time);
		dur  = longint'($signed(tl_live_dur));
		fout = longint'(shadow_cfg.fade_out);
		if (shadow_cfg.infinite_mode)
			return 1'b0;
		return now_l >= st + dur - fout;
	endfunction

	function automatic envelope_t advance_timer(logic [1:0] cmd, logic [30:0] now_t);
		longint    now_l, st, rel, dur, fin, fout, peak, divisor, quo, longer, w;
		logic [31:0] frame;
		bit        inf;
		envelope_t r;
		now_l = longint'(now_t);
		st    = longint'(shadow_cfg.start_time);
		rel   = now_l - st;
		fin   = longint'(shadow_cfg.fade_in);
		fout  = longint'(shadow_cfg.fade_out);
		peak  = longint'(shadow_cfg.peak_weight);
		inf   = shadow_cfg.infinite_mode;
		case (cmd)
			fet_pkg::CMD_TICK: begin
				tl_cur_rel  = {1'b0, now_t} - {1'b0, shadow_cfg.start_time};
				frame       = tl_cur_rel - tl_last_rel;
				tl_last_rel = tl_cur_rel;
				if (!tl_paused) begin
					divisor = longint'(shadow_cfg.time_divider);
					if (divisor == 0)
						divisor = 1;
					quo       = longint'($signed(frame)) / divisor;
					tl_base   = tl_base + quo[31:0];
					tl_sample = tl_base + shadow_cfg.time_offset;
				end
			end
			fet_pkg::CMD_STOP: begin
				if (!fading_out(now_l)) begin
					longer = rel + fout;
					if (longer > MAX_TICK)
						longer = MAX_TICK;
					tl_live_dur = longer[31:0];
				end
			end
			fet_pkg::CMD_PAUSE: begin
				tl_paused   = 1'b1;
				tl_last_rel = tl_cur_rel;
				tl_base     = tl_sample;
			end
			default: tl_paused = 1'b0;
		endcase

		dur        = longint'($signed(tl_live_dur));
		r.pending  = rel < 0;
		r.active   = !r.pending && (inf || now_l < st + dur);
		r.stopping = fading_out(now_l);
		r.expired  = !inf && now_l >= st + dur;
		if (!r.active)
			w = 0;
		else if (!inf && fout > 0 && rel > dur - fout)
			w = (peak * (dur - rel)) / fout;
		else if (fin > 0 && rel < fin)
			w = (peak * rel) / fin;
		else
			w = peak;
		r.weight      = w[16:0];
		r.sample_time = tl_sample;
		return r;
	endfunction

	task automatic apb_access(input bit wr, input logic [2:0] idx, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] rd, mask;
		apb_access(1'b1, idx, value, rd);
		mask = 32'h7FFF_FFFF;
		case (idx)
			fet_pkg::REG_START_TIME: shadow_cfg.start_time = value[30:0];
			fet_pkg::REG_PLAY_DURATION: begin
				shadow_cfg.play_duration = value[30:0];
				tl_live_dur = {1'b0, value[30:0]};
			end
			fet_pkg::REG_INFINITE_MODE: begin
				shadow_cfg.infinite_mode = value[0];
				mask = 32'h1;
			end
			fet_pkg::REG_FADE_IN: shadow_cfg.fade_in = value[30:0];
			fet_pkg::REG_FADE_OUT: shadow_cfg.fade_out = value[30:0];
			fet_pkg::REG_PEAK_WEIGHT: begin
				shadow_cfg.peak_weight = value[16:0];
				mask = 32'h1FFFF;
			end
			fet_pkg::REG_TIME_DIVIDER: begin
				shadow_cfg.time_divider = value[10:0];
				mask = 32'h7FF;
			end
			default: begin
				shadow_cfg.time_offset = value;
				mask = 32'hFFFF_FFFF;
			end
		endcase
		apb_access(1'b0, idx, '0, rd);
		if (rd !== (value & mask))
			log_failure($sformatf("register %0d readback: expected %h, got %h",
				idx, value & mask, rd));
	endtask

	task automatic send_request(input logic [1:0] cmd, input logic [30:0] now_t,
		input bit typed, input envelope_t known);
		envelope_t predicted;
		int        gap;
		if (!no_idle && $urandom_range(0, 99) < 8) begin
			items_ch.valid <= 1'b0;
			gap = $urandom_range(1, 6);
			repeat (gap) @(posedge clk);
		end
		items_ch.valid    <= 1'b1;
		items_ch.command  <= cmd;
		items_ch.now_time <= now_t;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
		predicted = advance_timer(cmd, now_t);
		due_envelopes.push_back(typed ? known : predicted);
	endtask

	// drop valid and wait for every outstanding result
	task automatic settle();
		items_ch.valid <= 1'b0;
		while (due_envelopes.size() != 0) @(posedge clk);
	endtask

	function automatic void add_write(logic [2:0] idx, logic [31:0] value);
		plan_row_t row;
		row = '{is_write: 1'b1, idx: idx, value: value, cmd: fet_pkg::CMD_TICK, typed: 1'b0,
			known: '0};
		plan_rows.push_back(row);
	endfunction

	function automatic void add_request(logic [1:0] cmd, logic [30:0] now_t,
		bit typed = 1'b0, envelope_t known = '0);
		plan_row_t row;
		row = '{is_write: 1'b0, idx: fet_pkg::REG_START_TIME, value: {1'b0, now_t}, cmd: cmd,
			typed: typed, known: known};
		plan_rows.push_back(row);
	endfunction

	function automatic logic [31:0] pick_ticks(logic [31:0] typical_max);
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'h7FFF_FFFF;
			2: return $urandom & 32'h7FFF_FFFF;
			default: return $urandom_range(0, typical_max);
		endcase
	endfunction

	task automatic run_phase(input int n_requests);
		logic [31:0] st, dur, span, step_max;
		longint      t;
		int          r;
		logic [1:0]  cmd;
		logic [30:0] now_t;
		settle();
		case ($urandom_range(0, 4))
			0: st = 32'd0;
			1: st = 32'h7FFF_FFFF - $urandom_range(0, 50000);
			2: st = $urandom & 32'h7FFF_FFFF;
			default: st = $urandom_range(0, 100000);
		endcase
		dur = pick_ticks(20000);
		write_reg(fet_pkg::REG_START_TIME, st);
		write_reg(fet_pkg::REG_PLAY_DURATION, dur);
		write_reg(fet_pkg::REG_INFINITE_MODE, {31'd0, $urandom_range(0, 3) == 0});
		write_reg(fet_pkg::REG_FADE_IN, pick_ticks(dur / 2 + 1));
		write_reg(fet_pkg::REG_FADE_OUT, pick_ticks(dur / 2 + 1));
		case ($urandom_range(0, 5))
			0: write_reg(fet_pkg::REG_PEAK_WEIGHT, 32'd0);
			1: write_reg(fet_pkg::REG_PEAK_WEIGHT, 32'h1FFFF);
			2: write_reg(fet_pkg::REG_PEAK_WEIGHT, $urandom & 32'h1FFFF);
			default: write_reg(fet_pkg::REG_PEAK_WEIGHT, {15'd0, fet_pkg::PEAK_WEIGHT_RESET});
		endcase
		case ($urandom_range(0, 6))
			0: write_reg(fet_pkg::REG_TIME_DIVIDER, 32'd0);
			1: write_reg(fet_pkg::REG_TIME_DIVIDER, 32'd2047);
			2: write_reg(fet_pkg::REG_TIME_DIVIDER, 32'd1024);
			3: write_reg(fet_pkg::REG_TIME_DIVIDER, $urandom & 32'h7FF);
			default: write_reg(fet_pkg::REG_TIME_DIVIDER, $urandom_range(1, 8));
		endcase
		case ($urandom_range(0, 3))
			0: write_reg(fet_pkg::REG_TIME_OFFSET, 32'h8000_0000);
			1: write_reg(fet_pkg::REG_TIME_OFFSET, 32'h7FFF_FFFF);
			default: write_reg(fet_pkg::REG_TIME_OFFSET, $urandom);
		endcase

		// sweep from before start to past end, with some noise requests mixed in
		span     = (dur == 0) ? 32'd2000 : dur;
		step_max = span / 50 + 2;
		t        = longint'(st) - longint'($urandom_range(0, span / 8 + 10));
		for (int i = 0; i < n_requests; i++) begin
			if ($urandom_range(0, 99) < 10) begin
				cmd   = 2'($urandom_range(0, 3));
				now_t = 31'($urandom);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					cmd = fet_pkg::CMD_TICK;
				else if (r < 80)
					cmd = fet_pkg::CMD_STOP;
				else if (r < 90)
					cmd = fet_pkg::CMD_PAUSE;
				else
					cmd = fet_pkg::CMD_RESUME;
				if (t < 0)
					t = 0;
				if (t > MAX_TICK)
					t = MAX_TICK;
				now_t = t[30:0];
				if ($urandom_range(0, 99) < 5)
					t = t - longint'($urandom_range(0, step_max));
				else
					t = t + longint'($urandom_range(0, step_max));
			end
			send_request(cmd, now_t, 1'b0, '0);
		end
	endtask

	// result side
	initial begin
		envelope_t got, want;
		results_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (results_ch.valid && results_ch.ready) begin
				got = '{weight: results_ch.weight, sample_time: results_ch.sample_time,
					pending: results_ch.pending, active: results_ch.active,
					stopping: results_ch.stopping, expired: results_ch.expired};
				if (due_envelopes.size() == 0) begin
					log_failure("result with no request outstanding");
				end else begin
					want = due_envelopes.pop_front();
					if (got.weight !== want.weight || got.sample_time !== want.sample_time ||
						got.pending !== want.pending || got.active !== want.active ||
						got.stopping !== want.stopping || got.expired !== want.expired)
						log_failure($sformatf(
							"mismatch: exp w=%0d t=%0d p=%b a=%b s=%b e=%b, got w=%0d t=%0d p=%b a=%b s=%b e=%b",
							want.weight, $signed(want.sample_time), want.pending, want.active,
							want.stopping, want.expired, got.weight, $signed(got.sample_time),
							got.pending, got.active, got.stopping, got.expired));
				end
			end
			results_ch.ready <= no_idle || ($urandom_range(0, 99) >= 8);
		end
	end

	// ends the run when no handshake of any kind happens for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready) ||
				(psel && penable && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		arst_n            <= 1'b0;
		psel              <= 1'b0;
		penable           <= 1'b0;
		pwrite            <= 1'b0;
		paddr             <= '0;
		pwdata            <= '0;
		items_ch.valid    <= 1'b0;
		items_ch.command  <= fet_pkg::CMD_TICK;
		items_ch.now_time <= '0;

		shadow_cfg              = '0;
		shadow_cfg.peak_weight  = fet_pkg::PEAK_WEIGHT_RESET;
		shadow_cfg.time_divider = fet_pkg::TIME_DIVIDER_RESET;
		tl_live_dur = '0;
		tl_cur_rel  = '0;
		tl_last_rel = '0;
		tl_base     = '0;
		tl_sample   = '0;
		tl_paused   = 1'b0;

		// register defaults: zero duration, so everything from time 0 is expired
		add_request(fet_pkg::CMD_TICK, 31'd0, 1'b1, envelope_t'{weight: 17'd0,
			sample_time: 32'd0, pending: 1'b0, active: 1'b0, stopping: 1'b1, expired: 1'b1});
		add_request(fet_pkg::CMD_TICK, 31'h7FFF_FFFF, 1'b1, envelope_t'{weight: 17'd0,
			sample_time: 32'h7FFF_FFFF, pending: 1'b0, active: 1'b0, stopping: 1'b1,
			expired: 1'b1});

		// ordinary job with both ramps, odd divider and negative offset
		add_write(fet_pkg::REG_START_TIME, 32'd1000);
		add_write(fet_pkg::REG_PLAY_DURATION, 32'd5000);
		add_write(fet_pkg::REG_INFINITE_MODE, 32'd0);
		add_write(fet_pkg::REG_FADE_IN, 32'd500);
		add_write(fet_pkg::REG_FADE_OUT, 32'd1000);
		add_write(fet_pkg::REG_TIME_DIVIDER, 32'd3);
		add_write(fet_pkg::REG_TIME_OFFSET, 32'hFFFF_FF9C);
		add_request(fet_pkg::CMD_TICK, 31'd0);
		add_request(fet_pkg::CMD_TICK, 31'd1000);
		add_request(fet_pkg::CMD_TICK, 31'd1250);
		add_request(fet_pkg::CMD_TICK, 31'd3000);
		add_request(fet_pkg::CMD_PAUSE, 31'd3100);
		add_request(fet_pkg::CMD_TICK, 31'd3400);
		add_request(fet_pkg::CMD_RESUME, 31'd3500);
		add_request(fet_pkg::CMD_TICK, 31'd3600);
		add_request(fet_pkg::CMD_TICK, 31'd5500);
		add_request(fet_pkg::CMD_STOP, 31'd3000);
		add_request(fet_pkg::CMD_STOP, 31'd3500);   // already fading out: ignored
		add_request(fet_pkg::CMD_TICK, 31'd2999);   // time going backwards
		add_request(fet_pkg::CMD_TICK, 31'd6000);

		// never-ending job, zero divider, peak above 1.0
		add_write(fet_pkg::REG_PEAK_WEIGHT, 32'h1FFFF);
		add_write(fet_pkg::REG_TIME_DIVIDER, 32'd0);
		add_write(fet_pkg::REG_INFINITE_MODE, 32'd1);
		add_request(fet_pkg::CMD_TICK, 31'd2000);
		add_request(fet_pkg::CMD_TICK, 31'd1100);
		add_request(fet_pkg::CMD_STOP, 31'd1500);

		// start, duration, fade-out, divider, offset at the top; zero peak and fade-in
		add_write(fet_pkg::REG_INFINITE_MODE, 32'd0);
		add_write(fet_pkg::REG_START_TIME, 32'h7FFF_FFFF);
		add_write(fet_pkg::REG_PLAY_DURATION, 32'h7FFF_FFFF);
		add_write(fet_pkg::REG_FADE_IN, 32'd0);
		add_write(fet_pkg::REG_FADE_OUT, 32'h7FFF_FFFF);
		add_write(fet_pkg::REG_PEAK_WEIGHT, 32'd0);
		add_write(fet_pkg::REG_TIME_DIVIDER, 32'd2047);
		add_write(fet_pkg::REG_TIME_OFFSET, 32'h7FFF_FFFF);
		add_request(fet_pkg::CMD_TICK, 31'h7FFF_FFFE);
		add_request(fet_pkg::CMD_TICK, 31'h7FFF_FFFF);
		add_request(fet_pkg::CMD_STOP, 31'h7FFF_FFFF);

		// huge fade-in, no fade-out: stop ends the job at once
		add_write(fet_pkg::REG_START_TIME, 32'd0);
		add_write(fet_pkg::REG_PLAY_DURATION, 32'd100);
		add_write(fet_pkg::REG_FADE_IN, 32'h7FFF_FFFF);
		add_write(fet_pkg::REG_FADE_OUT, 32'd0);
		add_write(fet_pkg::REG_PEAK_WEIGHT, 32'd65536);
		add_write(fet_pkg::REG_TIME_OFFSET, 32'h8000_0000);
		add_request(fet_pkg::CMD_TICK, 31'd50);
		add_request(fet_pkg::CMD_STOP, 31'd50);
		add_request(fet_pkg::CMD_PAUSE, 31'd60);
		add_request(fet_pkg::CMD_RESUME, 31'd60);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan_rows[i]) begin
			if (plan_rows[i].is_write) begin
				settle();
				write_reg(plan_rows[i].idx, plan_rows[i].value);
			end else begin
				send_request(plan_rows[i].cmd, plan_rows[i].value[30:0], plan_rows[i].typed,
					plan_rows[i].known);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			no_idle = (p == 4 || p == 5);
			run_phase(PHASE_REQUESTS);
		end
		no_idle = 1'b0;

		settle();
		repeat (100) @(posedge clk);
		if (bad_count == 0 && due_envelopes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
